// ----- sv/rde_pkg.sv -----
// Shared constants, types and the digit-to-ASCII mapping of the radix digit emitter.
package rde_pkg;

  localparam int VALUE_BITS_DEF = 31;
  localparam int RADIX_W        = 6;
  localparam int CHAR_W         = 7;
  localparam int CFG_DATA_W     = 32;
  localparam int CFG_ADDR_W     = 3;

  localparam logic [RADIX_W-1:0] RADIX_RESET    = 6'd10;
  localparam logic [RADIX_W-1:0] RADIX_MIN      = 6'd2;
  localparam logic [RADIX_W-1:0] RADIX_MAX      = 6'd36;
  localparam logic [RADIX_W-1:0] DECIMAL_DIGITS = 6'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

  localparam logic REG_RADIX = 1'b0;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_DIV   = 5'b00010,
    ST_FETCH = 5'b00100,
    ST_LOAD  = 5'b01000,
    ST_SEND  = 5'b10000
  } state_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [RADIX_W-1:0] d);
    logic [CHAR_W-1:0] c;
    if (d < DECIMAL_DIGITS) begin
      c = ASCII_ZERO + {1'b0, d};
    end else begin
      c = ASCII_A + {1'b0, d - DECIMAL_DIGITS};
    end
    return c;
  endfunction

endpackage

// ----- sv/rde_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
module rde_ram #(
  parameter int WIDTH = 6,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/radix_digit_emitter.sv -----
// Top level: bit-serial radix conversion of one word into ASCII digits, MSD first.
// Each digit is one divider pass over all VALUE_BITS bits (one quotient bit a cycle).
// A word with n digits runs n divider passes, then each digit goes out through FETCH
// (RAM read), LOAD and SEND, plus any output stall; one word at a time.
// A zero word produces no digits and the block is ready again on the next cycle.
// rst_n is synchronous, active low: radix returns to 10, control state is cleared.
module radix_digit_emitter
  import rde_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [VALUE_BITS-1:0] in_value,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CHAR_W-1:0]     out_digit_char,
  output logic                  out_last_digit,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  localparam int DEPTH = VALUE_BITS + 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int BW    = $clog2(VALUE_BITS);

  state_t                state_r, state_nxt;
  logic [RADIX_W-1:0]    radix_r;
  logic [RADIX_W-1:0]    base_r, base_nxt;
  logic [VALUE_BITS-1:0] q_r, q_nxt;
  logic [RADIX_W-1:0]    rem_r, rem_nxt;
  logic [BW-1:0]         bit_cnt_r, bit_cnt_nxt;
  logic [AW-1:0]         cnt_r, cnt_nxt;
  logic [AW-1:0]         idx_r, idx_nxt;
  logic [CHAR_W-1:0]     char_r, char_nxt;
  logic                  last_r, last_nxt;

  logic [RADIX_W:0]      trial;
  logic                  ge;
  logic [VALUE_BITS-1:0] q_step;
  logic [RADIX_W-1:0]    rem_step;
  logic                  ram_we;
  logic [RADIX_W-1:0]    ram_rdata;
  logic                  cfg_wr;
  logic [RADIX_W-1:0]    eff_radix;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_RADIX);
  assign prdata = (paddr[2] == REG_RADIX) ? CFG_DATA_W'(radix_r) : '0;

  always_comb begin
    eff_radix = radix_r;
    if (radix_r < RADIX_MIN) begin
      eff_radix = RADIX_MIN;
    end
    if (radix_r > RADIX_MAX) begin
      eff_radix = RADIX_MAX;
    end
  end

  // one restoring division step
  assign trial    = {rem_r, q_r[VALUE_BITS-1]};
  assign ge       = trial >= {1'b0, base_r};
  assign rem_step = ge ? RADIX_W'(trial - {1'b0, base_r}) : trial[RADIX_W-1:0];
  assign q_step   = {q_r[VALUE_BITS-2:0], ge};

  assign in_ready       = (state_r == ST_IDLE);
  assign out_valid      = (state_r == ST_SEND);
  assign out_digit_char = char_r;
  assign out_last_digit = last_r;
  assign ram_we         = (state_r == ST_DIV) && (bit_cnt_r == BW'(VALUE_BITS - 1));

  always_comb begin
    state_nxt   = state_r;
    base_nxt    = base_r;
    q_nxt       = q_r;
    rem_nxt     = rem_r;
    bit_cnt_nxt = bit_cnt_r;
    cnt_nxt     = cnt_r;
    idx_nxt     = idx_r;
    char_nxt    = char_r;
    last_nxt    = last_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          base_nxt    = eff_radix;
          q_nxt       = in_value;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          cnt_nxt     = '0;
          if (in_value != '0) begin
            state_nxt = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        q_nxt       = q_step;
        rem_nxt     = rem_step;
        bit_cnt_nxt = bit_cnt_r + 1'b1;
        if (ram_we) begin
          cnt_nxt     = cnt_r + 1'b1;
          rem_nxt     = '0;
          bit_cnt_nxt = '0;
          if (q_step == '0) begin
            idx_nxt   = cnt_r;
            state_nxt = ST_FETCH;
          end
        end
      end
      ST_FETCH: begin
        state_nxt = ST_LOAD;
      end
      ST_LOAD: begin
        char_nxt  = digit_to_ascii(ram_rdata);
        last_nxt  = (idx_r == '0);
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        if (out_ready) begin
          if (last_r) begin
            state_nxt = ST_IDLE;
          end else begin
            idx_nxt   = idx_r - 1'b1;
            state_nxt = ST_FETCH;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      radix_r   <= RADIX_RESET;
      cnt_r     <= '0;
      bit_cnt_r <= '0;
      rem_r     <= '0;
      q_r       <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      bit_cnt_r <= bit_cnt_nxt;
      rem_r     <= rem_nxt;
      q_r       <= q_nxt;
      if (cfg_wr) begin
        radix_r <= pwdata[RADIX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    base_r <= base_nxt;
    idx_r  <= idx_nxt;
    char_r <= char_nxt;
    last_r <= last_nxt;
  end

  rde_ram #(
    .WIDTH (RADIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cnt_r),
    .wdata (rem_step),
    .raddr (idx_r),
    .rdata (ram_rdata)
  );

endmodule

// ----- sv/rde_checker.sv -----
// Port-level assertions for the radix digit emitter, bound to the top level.
module rde_checker
  import rde_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic [VALUE_BITS-1:0] in_value,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [CHAR_W-1:0]     out_digit_char,
  input logic                  out_last_digit
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_digit_char)
      && $stable(out_last_digit))
    else $error("stalled output word changed");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_digit_char >= 7'h30 && out_digit_char <= 7'h39)
      || (out_digit_char >= 7'h41 && out_digit_char <= 7'h5A))
    else $error("digit character out of range");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while digits pending");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last_digit |=> !out_valid && in_ready)
    else $error("output continued after last digit");

  a_accept_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid && (in_ready == ($past(in_value) == '0)))
    else $error("wrong state after input accepted");

endmodule

bind radix_digit_emitter rde_checker #(
  .VALUE_BITS (VALUE_BITS)
) u_rde_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_value       (in_value),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_digit_char (out_digit_char),
  .out_last_digit (out_last_digit)
);

// ----- dv/radix_digit_emitter_test.sv -----
// Self-checking testbench for radix_digit_emitter: directed and random words, digit prediction.
`timescale 1ns / 1ps

module radix_digit_emitter_test;
  import rde_pkg::*;

  localparam int VB          = VALUE_BITS_DEF;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int IDLE_PCT    = 18;
  localparam int SETTLE      = 64;

  localparam logic [CFG_ADDR_W-1:0] RADIX_ADDR = CFG_ADDR_W'(4 * int'(REG_RADIX));
  localparam logic [CFG_ADDR_W-1:0] SPARE_ADDR = CFG_ADDR_W'(4);
  localparam logic [VB-1:0]         VALUE_MAX  = {VB{1'b1}};

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } digit_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [VB-1:0]         in_value = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [CHAR_W-1:0]     out_digit_char;
  logic                  out_last_digit;
  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic [VB-1:0]      pending_words[$];
  digit_t             due_digits[$];
  digit_t             want_digit;
  logic [RADIX_W-1:0] radix_cfg = RADIX_RESET;
  logic               calm = 1'b0;
  int                 errors = 0;
  int                 cycles = 0;

  radix_digit_emitter #(.VALUE_BITS(VB)) dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_digit_char (out_digit_char),
    .out_last_digit (out_last_digit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic [RADIX_W-1:0] clamp_radix(logic [RADIX_W-1:0] r);
    if (r < RADIX_MIN) return RADIX_MIN;
    if (r > RADIX_MAX) return RADIX_MAX;
    return r;
  endfunction

  // Remainders come out least significant first; queue them most significant first.
  function automatic void predict_digits(logic [VB-1:0] value);
    logic [RADIX_W-1:0] base;
    logic [RADIX_W-1:0] rems [VB+1];
    logic [VB-1:0]      quot;
    int                 n;
    digit_t             d;
    base = clamp_radix(radix_cfg);
    quot = value;
    n = 0;
    while (quot != 0 && n < VB + 1) begin
      rems[n] = RADIX_W'(quot % base);
      quot = quot / base;
      n++;
    end
    for (int k = n - 1; k >= 0; k--) begin
      if (rems[k] < DECIMAL_DIGITS) begin
        d.code = ASCII_ZERO + CHAR_W'(rems[k]);
      end else begin
        d.code = ASCII_A + CHAR_W'(rems[k] - DECIMAL_DIGITS);
      end
      d.last = (k == 0);
      due_digits.push_back(d);
    end
  endfunction

  // Mix of zero, short, full-width and radix-power boundary words.
  function automatic logic [VB-1:0] pick_value(logic [RADIX_W-1:0] base);
    longint pw;
    int     k;
    pw = 1;
    k = $urandom_range(1, VB);
    case ($urandom_range(9))
      0: return '0;
      1, 2: return VB'($urandom_range(0, 200));
      3, 4: return VB'($urandom);
      5, 6: begin
        repeat (k) if (pw * base <= longint'(VALUE_MAX)) pw = pw * base;
        return $urandom_range(1) ? VB'(pw) : VB'(pw - 1);
      end
      default: return VB'($urandom >> $urandom_range(0, 31));
    endcase
  endfunction

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr,
                           input logic [CFG_DATA_W-1:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if ((addr >> 2) == CFG_ADDR_W'(REG_RADIX)) radix_cfg = data[RADIX_W-1:0];
  endtask

  task automatic wait_idle();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || due_digits.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Word driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) predict_digits(in_value);
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          in_valid <= 1'b1;
          in_value <= pending_words.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Digit monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      if (out_valid && out_ready) begin
        if (due_digits.size() == 0) begin
          errors++;
          $display("%0t: unexpected digit: expected none, actual char %0d last %0b",
                   $time, out_digit_char, out_last_digit);
        end else begin
          want_digit = due_digits.pop_front();
          if (out_digit_char !== want_digit.code) begin
            errors++;
            $display("%0t: digit_char mismatch: expected %0d, actual %0d",
                     $time, want_digit.code, out_digit_char);
          end
          if (out_last_digit !== want_digit.last) begin
            errors++;
            $display("%0t: last_digit mismatch: expected %0b, actual %0b",
                     $time, want_digit.last, out_last_digit);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("radix_digit_emitter verification failed");
      $finish;
    end
  end

  initial begin
    logic [RADIX_W-1:0] r;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // decimal out of reset
    pending_words.push_back('0);
    pending_words.push_back(VB'(1));
    pending_words.push_back(VB'(9));
    pending_words.push_back(VB'(10));
    pending_words.push_back(VALUE_MAX);
    pending_words.push_back(VB'(1234567890));
    wait_idle();

    write_reg(RADIX_ADDR, CFG_DATA_W'(RADIX_MAX));
    pending_words.push_back(VB'(35));
    pending_words.push_back(VB'(36));
    pending_words.push_back(VB'(1295));
    pending_words.push_back(VALUE_MAX);
    wait_idle();

    write_reg(RADIX_ADDR, CFG_DATA_W'(RADIX_MIN));
    pending_words.push_back(VB'(1));
    pending_words.push_back(VALUE_MAX);
    pending_words.push_back(VB'(32'h2AAA_AAAA));
    pending_words.push_back(VB'(32'h5555_5555));
    wait_idle();

    // below two and above thirty-six saturate
    write_reg(RADIX_ADDR, 32'd0);
    pending_words.push_back(VB'(6));
    wait_idle();
    write_reg(RADIX_ADDR, 32'd1);
    pending_words.push_back(VB'(7));
    wait_idle();
    write_reg(RADIX_ADDR, 32'hFFFF_FFFF);
    pending_words.push_back(VB'(1295));
    wait_idle();
    write_reg(RADIX_ADDR, 32'd37);
    pending_words.push_back(VB'(46655));
    wait_idle();

    // unmapped register: radix must stay put
    write_reg(SPARE_ADDR, 32'd3);
    pending_words.push_back(VB'(100));
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0: r = RADIX_MIN;
        1: r = RADIX_MAX;
        2: r = '0;
        3: r = '1;
        default: r = RADIX_W'($urandom_range(0, 63));
      endcase
      if (p >= 4) write_reg(CFG_ADDR_W'($urandom_range(4, 7)), $urandom);
      write_reg(RADIX_ADDR, ($urandom & ~CFG_DATA_W'(6'h3F)) | CFG_DATA_W'(r));
      calm = (p == 5);
      repeat (33) pending_words.push_back(pick_value(clamp_radix(r)));
      wait_idle();
      calm = 1'b0;
    end

    if (errors == 0) begin
      $display("radix_digit_emitter verification clean");
    end else begin
      $display("radix_digit_emitter verification failed");
    end
    $finish;
  end

endmodule
